### rtl/core/cdq_pkg.sv
// ----------------------------------------------------------------------------
// cdq_pkg
// Shared types and codes for the circular double-ended queue unit.
// ----------------------------------------------------------------------------
package cdq_pkg;

    localparam int DEPTH_DEF      = 8;
    localparam int DATA_WIDTH_DEF = 32;
    localparam int FIELD_W        = 32;
    localparam int OCC_W          = 4;

    localparam logic [1:0] ACT_PUSH_BACK  = 2'd0;
    localparam logic [1:0] ACT_PUSH_FRONT = 2'd1;
    localparam logic [1:0] ACT_POP_BACK   = 2'd2;
    localparam logic [1:0] ACT_POP_FRONT  = 2'd3;

    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic [1:0]         action;
        logic [FIELD_W-1:0] push_value;
    } req_word_t;

    typedef struct packed {
        logic [FIELD_W-1:0] popped_value;
        logic [1:0]         status;
        logic [OCC_W-1:0]   occupancy;
        logic               is_empty;
        logic               is_full;
    } rsp_word_t;

    typedef struct packed {
        logic accept;
        logic load_rd;
    } ctrl_cmd_t;

    typedef struct packed {
        logic pop_pending;
    } ctrl_sts_t;

endpackage

### rtl/core/cdq_ram.sv
// ----------------------------------------------------------------------------
// cdq_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module cdq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/core/cdq_ctrl.sv
// ----------------------------------------------------------------------------
// cdq_ctrl
// Handshake controller: accept, optional RAM read wait, result hold.
// ----------------------------------------------------------------------------
module cdq_ctrl
    import cdq_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    output logic       req_ready,
    output logic       rsp_valid,
    input  logic       rsp_ready,
    input  ctrl_sts_t  sts,
    output ctrl_cmd_t  cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_OUT  = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = sts.pop_pending ? S_READ : S_OUT;
                end
            end
            S_READ:
            begin
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (rsp_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign req_ready   = (state_reg == S_IDLE);
    assign rsp_valid   = (state_reg == S_OUT);
    assign cmd.accept  = req_valid && (state_reg == S_IDLE);
    assign cmd.load_rd = (state_reg == S_READ);

endmodule

### rtl/core/cdq_dp.sv
// ----------------------------------------------------------------------------
// cdq_dp
// Datapath: pointers, occupancy count, slot RAM and result register.
// ----------------------------------------------------------------------------
module cdq_dp
    import cdq_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  req_word_t  req,
    input  ctrl_cmd_t  cmd,
    output ctrl_sts_t  sts,
    output rsp_word_t  rsp
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] PTR_LAST = AW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

    logic [AW-1:0] front_reg, front_next;
    logic [AW-1:0] back_reg, back_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    rsp_word_t     rsp_reg, rsp_next;

    logic [AW-1:0]         front_inc, front_dec, back_inc, back_dec, idx;
    logic [CW-1:0]         cnt_after;
    logic                  is_push, full, empty, ok;
    logic [DATA_WIDTH-1:0] rdata;

    assign is_push = ~req.action[1];
    assign full    = (cnt_reg == CNT_FULL);
    assign empty   = (cnt_reg == '0);
    assign ok      = is_push ? !full : !empty;

    assign front_inc = (front_reg == PTR_LAST) ? '0 : front_reg + 1'b1;
    assign front_dec = (front_reg == '0) ? PTR_LAST : front_reg - 1'b1;
    assign back_inc  = (back_reg == PTR_LAST) ? '0 : back_reg + 1'b1;
    assign back_dec  = (back_reg == '0) ? PTR_LAST : back_reg - 1'b1;

    always_comb
    begin
        front_next = front_reg;
        back_next  = back_reg;
        case (req.action)
            ACT_PUSH_BACK:
            begin
                idx       = back_reg;
                back_next = back_inc;
            end
            ACT_PUSH_FRONT:
            begin
                idx        = front_dec;
                front_next = front_dec;
            end
            ACT_POP_BACK:
            begin
                idx       = back_dec;
                back_next = back_dec;
            end
            ACT_POP_FRONT:
            begin
                idx        = front_reg;
                front_next = front_inc;
            end
            default:
            begin
                idx = front_reg;
            end
        endcase
    end

    assign cnt_next  = is_push ? cnt_reg + 1'b1 : cnt_reg - 1'b1;
    assign cnt_after = ok ? cnt_next : cnt_reg;

    always_comb
    begin
        rsp_next = rsp_reg;
        if (cmd.accept)
        begin
            rsp_next.popped_value = '0;
            rsp_next.status       = ok ? ST_DONE : (is_push ? ST_FULL : ST_EMPTY);
            rsp_next.occupancy    = OCC_W'(cnt_after);
            rsp_next.is_empty     = (cnt_after == '0);
            rsp_next.is_full      = (cnt_after == CNT_FULL);
        end
        else if (cmd.load_rd)
        begin
            rsp_next.popped_value = FIELD_W'(rdata);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg <= '0;
            back_reg  <= '0;
            cnt_reg   <= '0;
        end
        else if (cmd.accept && ok)
        begin
            front_reg <= front_next;
            back_reg  <= back_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    cdq_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (cmd.accept && ok && is_push),
        .waddr (idx),
        .wdata (DATA_WIDTH'(req.push_value)),
        .re    (cmd.accept && ok && !is_push),
        .raddr (idx),
        .rdata (rdata)
    );

    assign sts.pop_pending = ok && !is_push;
    assign rsp             = rsp_reg;

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_FULL)
        else $error("occupancy count above capacity");

    a_reject_hold: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.accept && !ok |=> $stable(cnt_reg) && $stable(front_reg) && $stable(back_reg))
        else $error("rejected word changed queue state");

    a_idle_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd.accept |=> $stable(cnt_reg) && $stable(front_reg) && $stable(back_reg))
        else $error("queue state moved without an accepted word");

    a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == '0) || (cnt_reg == CNT_FULL) |-> front_reg == back_reg)
        else $error("pointers disagree with empty or full count");

endmodule

### rtl/core/circular_double_ended_queue_unit.sv
// ----------------------------------------------------------------------------
// circular_double_ended_queue_unit
// Fixed-capacity double-ended queue kept in a circular RAM buffer.
// ----------------------------------------------------------------------------
// Usage:
//   req channel (req_valid/req_ready/req) carries one word per action:
//   push back, push front, pop back or pop front. rsp channel
//   (rsp_valid/rsp_ready/rsp) returns exactly one word per request with
//   the popped value, status, occupancy and empty/full flags.
//   A push into a full queue or a pop from an empty one is rejected with
//   the matching status and leaves the queue unchanged.
//   Timing: a push or rejected action shows its result in the cycle after
//   acceptance; a successful pop goes through the registered RAM read
//   and then the result register. One action is in flight at a time;
//   req_ready is low until the result has been taken.
//   Reset empties the queue (pointers and count cleared); slot contents
//   are not cleared and need no clearing pass. A stalled result simply
//   holds on rsp until rsp_ready.
// ----------------------------------------------------------------------------
module circular_double_ended_queue_unit
    import cdq_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_ready,
    input  req_word_t req,
    output logic      rsp_valid,
    input  logic      rsp_ready,
    output rsp_word_t rsp
);

    ctrl_cmd_t cmd;
    ctrl_sts_t sts;

    cdq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    cdq_dp #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .cmd   (cmd),
        .sts   (sts),
        .rsp   (rsp)
    );

endmodule

### tb/tb_circular_double_ended_queue_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_circular_double_ended_queue_unit
// Self-checking bench for the circular double-ended queue unit. A directed
// run covers empty and full rejects, extreme words and pointer wrap at both
// ends. It is followed by random bursts that lean toward pushes, lean toward
// pops or are balanced, so the queue keeps hitting full and empty. Every
// response word is checked field by field against an in-bench deque model.
// Random idles are added on both channels, with one long response hold-off
// and three sender pauses until all responses are in.
// ----------------------------------------------------------------------------
module tb_circular_double_ended_queue_unit;
    import cdq_pkg::*;

    localparam int QDEPTH       = DEPTH_DEF;
    localparam int RAND_ITEMS   = 950;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int TAIL_CYCLES  = 10;
    localparam int HOLD_AT      = 399;
    localparam int HOLD_LEN     = 120;
    localparam int MAX_PRINTS   = 100;

    typedef struct packed {
        logic      drain;
        req_word_t word;
    } tx_item_t;

    logic      clk;
    logic      rst_n     = 1'b0;
    logic      req_valid = 1'b0;
    logic      req_ready;
    req_word_t req       = '0;
    logic      rsp_valid;
    logic      rsp_ready = 1'b0;
    rsp_word_t rsp;

    tx_item_t  pending[$];
    rsp_word_t exp_rsp[$];
    rsp_word_t want;

    logic [FIELD_W-1:0] dq_slot [QDEPTH];
    int dq_head  = 0;
    int dq_tail  = 0;
    int dq_fill  = 0;

    int total_items = 0;
    int sent_cnt    = 0;
    int rsp_cnt     = 0;
    int err_cnt     = 0;
    int cycle_cnt   = 0;
    int gap_left    = 0;
    int rdy_wait    = 0;
    int long_hold   = 0;
    int draw_w;

    circular_double_ended_queue_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
    end

    function automatic rsp_word_t deque_result(req_word_t w);
        rsp_word_t r;
        r = '0;
        r.status = ST_DONE;
        if (w.action == ACT_PUSH_BACK || w.action == ACT_PUSH_FRONT)
        begin
            if (dq_fill >= QDEPTH)
                r.status = ST_FULL;
            else if (w.action == ACT_PUSH_BACK)
            begin
                dq_slot[dq_tail] = w.push_value;
                dq_tail = (dq_tail + 1) % QDEPTH;
                dq_fill++;
            end
            else
            begin
                dq_head = (dq_head + QDEPTH - 1) % QDEPTH;
                dq_slot[dq_head] = w.push_value;
                dq_fill++;
            end
        end
        else if (dq_fill == 0)
            r.status = ST_EMPTY;
        else if (w.action == ACT_POP_BACK)
        begin
            dq_tail = (dq_tail + QDEPTH - 1) % QDEPTH;
            r.popped_value = dq_slot[dq_tail];
            dq_fill--;
        end
        else
        begin
            r.popped_value = dq_slot[dq_head];
            dq_head = (dq_head + 1) % QDEPTH;
            dq_fill--;
        end
        r.occupancy = OCC_W'(dq_fill);
        r.is_empty  = (dq_fill == 0);
        r.is_full   = (dq_fill == QDEPTH);
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [FIELD_W-1:0] got,
                                   logic [FIELD_W-1:0] exp_val);
        if (err_cnt < MAX_PRINTS)
            $display("MISMATCH word %0d %s: got %h, expected %h",
                     rsp_cnt, what, got, exp_val);
        err_cnt++;
    endtask

    function automatic void add_word(logic [1:0] act, logic [FIELD_W-1:0] value);
        tx_item_t t;
        t.drain           = 1'b0;
        t.word.action     = act;
        t.word.push_value = value;
        pending.insert(pending.size(), t);
        total_items++;
    endfunction

    function automatic void add_drain();
        tx_item_t t;
        t       = '0;
        t.drain = 1'b1;
        pending.insert(pending.size(), t);
    endfunction

    function automatic logic [FIELD_W-1:0] rand_value();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    // sender
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req       <= '0;
            gap_left  <= 0;
            sent_cnt  <= 0;
        end
        else
        begin
            if (req_valid && req_ready)
            begin
                exp_rsp.insert(exp_rsp.size(), deque_result(req));
                sent_cnt <= sent_cnt + 1;
            end
            if (req_valid && !req_ready)
                req_valid <= 1'b1;
            else if (gap_left != 0)
            begin
                gap_left  <= gap_left - 1;
                req_valid <= 1'b0;
            end
            else if (pending.size() != 0 && pending[0].drain)
            begin
                req_valid <= 1'b0;
                if (!(req_valid && req_ready) && sent_cnt == rsp_cnt)
                    pending.delete(0);
            end
            else if (pending.size() != 0)
            begin
                req       <= pending[0].word;
                req_valid <= 1'b1;
                pending.delete(0);
                gap_left  <= ((sent_cnt % 200) >= 150) ? 0 : $urandom_range(0, 5);
            end
            else
                req_valid <= 1'b0;
        end
    end

    // receiver and checker
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_ready <= 1'b0;
            rsp_cnt   <= 0;
            rdy_wait  <= 0;
            long_hold <= 0;
        end
        else
        begin
            if (rsp_valid && rsp_ready)
            begin
                if (exp_rsp.size() == 0)
                    report_mismatch("unexpected word", rsp.popped_value, '0);
                else
                begin
                    want = exp_rsp[0];
                    exp_rsp.delete(0);
                    if (rsp.popped_value !== want.popped_value)
                        report_mismatch("popped_value", rsp.popped_value,
                                        want.popped_value);
                    if (rsp.status !== want.status)
                        report_mismatch("status", FIELD_W'(rsp.status),
                                        FIELD_W'(want.status));
                    if (rsp.occupancy !== want.occupancy)
                        report_mismatch("occupancy", FIELD_W'(rsp.occupancy),
                                        FIELD_W'(want.occupancy));
                    if (rsp.is_empty !== want.is_empty)
                        report_mismatch("is_empty", FIELD_W'(rsp.is_empty),
                                        FIELD_W'(want.is_empty));
                    if (rsp.is_full !== want.is_full)
                        report_mismatch("is_full", FIELD_W'(rsp.is_full),
                                        FIELD_W'(want.is_full));
                end
                rsp_cnt <= rsp_cnt + 1;
            end

            if (rsp_valid && rsp_ready && rsp_cnt == HOLD_AT)
            begin
                long_hold <= HOLD_LEN;
                rsp_ready <= 1'b0;
            end
            else if (long_hold != 0)
            begin
                long_hold <= long_hold - 1;
                rsp_ready <= (long_hold == 1);
            end
            else if (rsp_valid && rsp_ready)
            begin
                draw_w = ((rsp_cnt % 256) >= 192) ? 0 : $urandom_range(0, 5);
                rdy_wait  <= draw_w;
                rsp_ready <= (draw_w == 0);
            end
            else if (rdy_wait != 0)
            begin
                rdy_wait  <= rdy_wait - 1;
                rsp_ready <= (rdy_wait == 1);
            end
            else
                rsp_ready <= 1'b1;
        end
    end

    initial
    begin
        int         n;
        int         blen;
        int         bias;
        int         k;
        bit         is_push;
        logic [1:0] act;

        // empty rejects, extreme words, wrap at both ends, full rejects
        add_word(ACT_POP_BACK,   32'h1234_5678);
        add_word(ACT_POP_FRONT,  32'hFFFF_FFFF);
        add_word(ACT_PUSH_BACK,  32'h0000_0000);
        add_word(ACT_PUSH_BACK,  32'hFFFF_FFFF);
        add_word(ACT_PUSH_FRONT, 32'hAAAA_AAAA);
        add_word(ACT_PUSH_FRONT, 32'h5555_5555);
        add_word(ACT_POP_BACK,   32'h0);
        add_word(ACT_POP_FRONT,  32'h0);
        for (k = 0; k < 6; k++)
            add_word(k[0] ? ACT_PUSH_FRONT : ACT_PUSH_BACK, $urandom);
        add_word(ACT_PUSH_BACK,  32'hDEAD_BEEF);
        add_word(ACT_PUSH_FRONT, 32'hCAFE_F00D);
        add_drain();
        for (k = 0; k < 8; k++)
            add_word(k[0] ? ACT_POP_BACK : ACT_POP_FRONT, $urandom);
        add_word(ACT_POP_FRONT, 32'h0);

        n = 0;
        while (n < RAND_ITEMS)
        begin
            blen = $urandom_range(8, 40);
            bias = $urandom_range(0, 3);
            for (k = 0; k < blen && n < RAND_ITEMS; k++)
            begin
                case (bias)
                    0:       is_push = ($urandom_range(0, 9) < 8);
                    1:       is_push = ($urandom_range(0, 9) < 2);
                    default: is_push = $urandom_range(0, 1);
                endcase
                if (is_push)
                    act = $urandom_range(0, 1) ? ACT_PUSH_FRONT : ACT_PUSH_BACK;
                else
                    act = $urandom_range(0, 1) ? ACT_POP_FRONT : ACT_POP_BACK;
                add_word(act, rand_value());
                n++;
                if (n == 300 || n == 650)
                    add_drain();
            end
        end

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        while (!(sent_cnt == total_items && rsp_cnt == total_items)
               && cycle_cnt < CYCLE_LIMIT)
            @(posedge clk);

        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("TIMEOUT after %0d cycles, %0d of %0d responses",
                     cycle_cnt, rsp_cnt, total_items);
            $display("Some tests failed");
        end
        else
        begin
            repeat (TAIL_CYCLES) @(posedge clk);
            if (exp_rsp.size() != 0)
                report_mismatch("missing responses", exp_rsp.size(), '0);
            if (err_cnt == 0)
                $display("All tests passed");
            else
                $display("Some tests failed");
        end
        $finish;
    end

endmodule
